// ----- hw/rtl/fpa_pkg.sv -----
// Shared types, codes and helpers for the Q24.8 fixed-point ALU.
// Holds the beat payload structs, the operation and status codes and the saturation helper.
// No dependencies.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } st_t;

  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } out_beat_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  // Turn a magnitude and sign into a 32-bit word, saturating at the bounds.
  function automatic clamp_t clamp_mag(logic [63:0] mag, logic neg);
    clamp_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        c.sat = 1'b1;
        c.val = WORD_MIN;
      end else begin
        c.val = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        c.sat = 1'b1;
        c.val = WORD_MAX;
      end else begin
        c.val = mag[31:0];
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/fpa_stream_if.sv -----
// Valid/ready stream channel used for the ALU's operation and result beats.
// The payload type is a parameter; the ALU uses the beat structs of fpa_pkg.
interface fpa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/fixed_point_alu_q24_8.sv -----
// Signed 32-bit fixed-point ALU (FRAC_BITS fraction bits, Q24.8 by default). Each beat on in_ch
// carries an op and two raw operands and gives exactly one beat on out_ch, in order. The block
// takes one beat per cycle whenever out_ch is ready. Every op runs through the same full pipeline,
// whose depth is set by the divider, which resolves one quotient bit per pipeline stage over 32 +
// FRAC_BITS stages. While a result waits on out_ch the whole pipeline holds and in_ch.ready is low.
// Multiply and divide round half away from zero; overflow saturates with status 1, divide by zero
// gives zero with status 2. Depends on fpa_pkg and fpa_stream_if.
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  fpa_stream_if.sink   in_ch,
  fpa_stream_if.source out_ch
);

  localparam int F    = FRAC_BITS;
  localparam int QW   = 32 + F;
  localparam int LAST = QW + 3;
  localparam logic [63:0] RND_HALF = 64'd1 << (F - 1);
  localparam logic [63:0] RND_NEG  = RND_HALF + 64'd1;

  typedef struct packed {
    fpa_pkg::op_t    op;
    logic [31:0]     res;
    logic            cmp;
    fpa_pkg::st_t    st;
    logic [63:0]     prod;
    logic            pneg;
    logic [QW-1:0]   num;
    logic [31:0]     den;
    logic [31:0]     rem;
    logic [QW-1:0]   quo;
    logic            neg;
  } stg_t;

  logic               adv;
  logic [LAST:0]      vld_r;
  logic [3:0]         s0_op_r;
  logic signed [31:0] s0_a_r;
  logic signed [31:0] s0_b_r;
  stg_t               stg_r   [LAST:1];
  stg_t               stg_nxt [LAST:1];
  logic signed [63:0] mul_p;

  function automatic fpa_pkg::clamp_t sat33(logic [32:0] s);
    fpa_pkg::clamp_t c;
    c.sat = s[32] ^ s[31];
    if (c.sat) begin
      c.val = s[32] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
    end else begin
      c.val = s[31:0];
    end
    return c;
  endfunction

  // One restoring division step: bring down a numerator bit, subtract when it fits.
  function automatic stg_t div_step(stg_t s);
    stg_t        t;
    logic [32:0] trial;
    logic        take;
    t     = s;
    trial = {s.rem, s.num[QW-1]};
    take  = (trial >= {1'b0, s.den});
    t.rem = take ? 32'(trial - {1'b0, s.den}) : trial[31:0];
    t.num = s.num << 1;
    t.quo = {s.quo[QW-2:0], take};
    return t;
  endfunction

  // Whole pipeline moves together; hold everything while the result beat waits.
  assign adv         = !vld_r[LAST] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op_r <= in_ch.data.op;
      s0_a_r  <= in_ch.data.operand_a;
      s0_b_r  <= in_ch.data.operand_b;
      for (int k = 1; k <= LAST; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign mul_p = s0_a_r * s0_b_r;

  // Setup stage: the ops that need no further stage, the product and the divider operands.
  always_comb begin
    stg_t            t;
    fpa_pkg::clamp_t c;
    logic [31:0]     abs_a;
    logic [31:0]     abs_b;
    logic            lt;
    logic            eq;
    logic [F:0]      top;
    t      = '0;
    c      = '0;
    t.op   = fpa_pkg::op_t'(s0_op_r);
    t.st   = fpa_pkg::ST_OK;
    abs_a  = s0_a_r[31] ? (~s0_a_r + 32'd1) : s0_a_r;
    abs_b  = s0_b_r[31] ? (~s0_b_r + 32'd1) : s0_b_r;
    lt     = (s0_a_r < s0_b_r);
    eq     = (s0_a_r == s0_b_r);
    top    = s0_a_r[31:31-F];
    t.prod = mul_p;
    t.num  = {abs_a, {F{1'b0}}};
    t.den  = abs_b;
    t.neg  = s0_a_r[31] ^ s0_b_r[31];
    unique case (t.op)
      fpa_pkg::OP_ADD: c = sat33({s0_a_r[31], s0_a_r} + {s0_b_r[31], s0_b_r});
      fpa_pkg::OP_SUB: c = sat33({s0_a_r[31], s0_a_r} - {s0_b_r[31], s0_b_r});
      fpa_pkg::OP_MUL: c = '0;
      fpa_pkg::OP_DIV: c = '0;
      fpa_pkg::OP_GT:  t.cmp = !lt && !eq;
      fpa_pkg::OP_LT:  t.cmp = lt;
      fpa_pkg::OP_GE:  t.cmp = !lt;
      fpa_pkg::OP_LE:  t.cmp = lt || eq;
      fpa_pkg::OP_EQ:  t.cmp = eq;
      fpa_pkg::OP_NE:  t.cmp = !eq;
      fpa_pkg::OP_MIN: c.val = lt ? s0_a_r : s0_b_r;
      fpa_pkg::OP_MAX: c.val = (!lt && !eq) ? s0_a_r : s0_b_r;
      fpa_pkg::OP_INC: c = sat33({s0_a_r[31], s0_a_r} + 33'd1);
      fpa_pkg::OP_DEC: c = sat33({s0_a_r[31], s0_a_r} - 33'd1);
      fpa_pkg::OP_FROM_INT: begin
        if ((&top) || !(|top)) begin
          c.val = s0_a_r << F;
        end else begin
          c.sat = 1'b1;
          c.val = s0_a_r[31] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
        end
      end
      fpa_pkg::OP_TO_INT: c.val = s0_a_r >>> F;
    endcase
    t.res = c.val;
    if (c.sat) begin
      t.st = fpa_pkg::ST_SAT;
    end
    if (t.op == fpa_pkg::OP_DIV && abs_b == 32'd0) begin
      t.st = fpa_pkg::ST_DIV0;
    end
    stg_nxt[1] = t;
  end

  for (genvar k = 2; k <= LAST; k++) begin : g_stage
    always_comb begin
      stg_t            t;
      fpa_pkg::clamp_t c;
      logic            inc;
      t   = stg_r[k-1];
      c   = '0;
      inc = 1'b0;
      if (k <= QW + 1) begin
        t = div_step(stg_r[k-1]);
      end
      if (k == 2) begin
        // magnitude of the product plus half an LSB, in one add
        t.pneg = stg_r[k-1].prod[63];
        t.prod = stg_r[k-1].prod[63] ? (~stg_r[k-1].prod + RND_NEG)
                                     : (stg_r[k-1].prod + RND_HALF);
      end
      if (k == 3 && stg_r[k-1].op == fpa_pkg::OP_MUL) begin
        c     = fpa_pkg::clamp_mag(stg_r[k-1].prod >> F, stg_r[k-1].pneg);
        t.res = c.val;
        t.st  = c.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
      end
      if (k == QW + 2) begin
        // round half up on the remainder: 2r >= d
        inc    = ({stg_r[k-1].rem, 1'b0} >= {1'b0, stg_r[k-1].den});
        t.prod = 64'({1'b0, stg_r[k-1].quo} + (QW+1)'(inc));
      end
      if (k == QW + 3 && stg_r[k-1].op == fpa_pkg::OP_DIV &&
          stg_r[k-1].st != fpa_pkg::ST_DIV0) begin
        c     = fpa_pkg::clamp_mag(stg_r[k-1].prod, stg_r[k-1].neg);
        t.res = c.val;
        t.st  = c.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
      end
      stg_nxt[k] = t;
    end
  end

  assign out_ch.valid             = vld_r[LAST];
  assign out_ch.data.result_value = stg_r[LAST].res;
  assign out_ch.data.compare_true = stg_r[LAST].cmp;
  assign out_ch.data.status       = stg_r[LAST].st;

`ifndef NO_ASSERTIONS
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && stg_r[LAST].cmp |-> stg_r[LAST].res == 32'd0 &&
                                       stg_r[LAST].st == fpa_pkg::ST_OK)
    else $error("compare result carries a value or a status");

  a_div0_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && stg_r[LAST].st == fpa_pkg::ST_DIV0 |->
      stg_r[LAST].op == fpa_pkg::OP_DIV && stg_r[LAST].res == 32'd0)
    else $error("divide-by-zero status on a non-divide or with non-zero value");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] && stg_r[LAST].st == fpa_pkg::ST_SAT |->
      stg_r[LAST].res == fpa_pkg::WORD_MAX || stg_r[LAST].res == fpa_pkg::WORD_MIN)
    else $error("saturated result is not at a bound");
`endif

endmodule

// ----- sim/fixed_point_alu_q24_8_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Q24.8 fixed-point ALU: directed edge cases, then random beats
// with random idling on both channels but for one back-to-back run, each result checked against
// an in-bench predictor. Depends on fpa_pkg, fpa_stream_if and fixed_point_alu_q24_8.
module fixed_point_alu_q24_8_tb;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = FRAC_BITS + 35;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct {
    fpa_pkg::op_t       op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    fpa_pkg::out_beat_t res;
  } alu_expect_t;

  logic clk;
  logic rst_n;

  fpa_stream_if #(.T(fpa_pkg::in_beat_t))  in_if ();
  fpa_stream_if #(.T(fpa_pkg::out_beat_t)) out_if ();

  fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  alu_expect_t pending_results[$];
  int          error_count;
  int          checked_count;
  int          sat_count;
  int          div0_count;
  int          cmp_held_count;
  int          op_sent[16];
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout after %0t", $realtime);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Clamp a wide value to the signed 32-bit range; the top bit flags saturation.
  function automatic logic [32:0] saturate(longint v);
    if (v > SAT_HI) return {1'b1, POS_MAX};
    if (v < SAT_LO) return {1'b1, NEG_MIN};
    return {1'b0, v[31:0]};
  endfunction

  function automatic fpa_pkg::out_beat_t alu_predict(fpa_pkg::op_t op, logic signed [31:0] a,
                                                     logic signed [31:0] b);
    fpa_pkg::out_beat_t r;
    longint      va;
    longint      vb;
    longint      p;
    logic [63:0] mag;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic        neg;
    logic [32:0] s;
    va = a;
    vb = b;
    r = '0;
    s = {1'b0, 32'd0};
    case (op)
      fpa_pkg::OP_ADD: s = saturate(va + vb);
      fpa_pkg::OP_SUB: s = saturate(va - vb);
      fpa_pkg::OP_MUL: begin
        p   = va * vb;
        neg = p < 0;
        mag = neg ? -p : p;
        // round half away from zero on the magnitude
        mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s   = saturate(neg ? -$signed(mag) : $signed(mag));
      end
      fpa_pkg::OP_DIV: begin
        if (vb == 0) begin
          r.status = fpa_pkg::ST_DIV0;
        end else begin
          num = (va < 0 ? -va : va);
          num = num << FRAC_BITS;
          den = (vb < 0 ? -vb : vb);
          quo = num / den;
          rem = num % den;
          if (rem >= den - rem) quo++;
          neg = (va < 0) != (vb < 0);
          s   = saturate(neg ? -$signed(quo) : $signed(quo));
        end
      end
      fpa_pkg::OP_GT: r.compare_true = va > vb;
      fpa_pkg::OP_LT: r.compare_true = va < vb;
      fpa_pkg::OP_GE: r.compare_true = va >= vb;
      fpa_pkg::OP_LE: r.compare_true = va <= vb;
      fpa_pkg::OP_EQ: r.compare_true = va == vb;
      fpa_pkg::OP_NE: r.compare_true = va != vb;
      fpa_pkg::OP_MIN: s = {1'b0, (va < vb) ? a : b};
      fpa_pkg::OP_MAX: s = {1'b0, (va > vb) ? a : b};
      fpa_pkg::OP_INC: s = saturate(va + 1);
      fpa_pkg::OP_DEC: s = saturate(va - 1);
      fpa_pkg::OP_FROM_INT: s = saturate(va * (64'sd1 <<< FRAC_BITS));
      default: s = {1'b0, a >>> FRAC_BITS};
    endcase
    if (op != fpa_pkg::OP_DIV || vb != 0) begin
      r.result_value = s[31:0];
      if (s[32]) r.status = fpa_pkg::ST_SAT;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: return w;
      3, 4:    return {{20{w[31]}}, w[11:0]};
      5:       return $signed(w) >>> $urandom_range(1, 30);
      6:       return w[0] ? POS_MAX - w[9:1] : NEG_MIN + w[9:1];
      7:       return {32{w[0]}};
      8:       return 32'd0;
      default: return w[0] ? {8'd0, w[23:0]} : -{8'd0, w[23:0]};
    endcase
  endfunction

  // Operands around the points where add, mul and from_int begin to saturate.
  function automatic logic [31:0] near_bound_word();
    logic [31:0] k;
    k = $urandom_range(0, 600);
    case ($urandom_range(0, 5))
      0:       return POS_MAX - k;
      1:       return NEG_MIN + k;
      2:       return 32'h0080_0000 + k - 300;
      3:       return -(32'h0080_0000 + k - 300);
      4:       return 32'h0010_0000 + k - 300;
      default: return -(32'h0008_0000 + k - 300);
    endcase
  endfunction

  task automatic send_op(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    fpa_pkg::in_beat_t beat;
    alu_expect_t       e;
    int                gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.op        = op;
    beat.operand_a = a;
    beat.operand_b = b;
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do @(posedge clk); while (!in_if.ready);
    e.op  = op;
    e.a   = a;
    e.b   = b;
    e.res = alu_predict(op, a, b);
    pending_results.push_back(e);
    op_sent[op]++;
  endtask

  task automatic send_random(bit near_bounds);
    logic [31:0] a;
    logic [31:0] b;
    a = near_bounds ? near_bound_word() : rand_word();
    b = near_bounds ? near_bound_word() : rand_word();
    if ($urandom_range(0, 7) == 0) b = a;
    send_op(fpa_pkg::op_t'($urandom_range(0, 15)), a, b);
  endtask

  task automatic wait_results_done(int limit);
    int n;
    n = 0;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Drive out_ch.ready with random stalls; check every result beat.
  initial begin
    alu_expect_t        e;
    fpa_pkg::out_beat_t got;
    int                 stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: value %h",
                                    got.result_value));
        end else begin
          e = pending_results.pop_front();
          checked_count++;
          if (got.result_value !== e.res.result_value)
            report_mismatch($sformatf("%s a=%h b=%h value got %h exp %h", e.op.name(),
                                      e.a, e.b, got.result_value, e.res.result_value));
          if (got.compare_true !== e.res.compare_true)
            report_mismatch($sformatf("%s a=%h b=%h compare got %b exp %b", e.op.name(),
                                      e.a, e.b, got.compare_true, e.res.compare_true));
          if (got.status !== e.res.status)
            report_mismatch($sformatf("%s a=%h b=%h status got %0d exp %0d", e.op.name(),
                                      e.a, e.b, got.status, e.res.status));
          if (e.res.status == fpa_pkg::ST_SAT) sat_count++;
          if (e.res.status == fpa_pkg::ST_DIV0) div0_count++;
          if (e.res.compare_true) cmp_held_count++;
        end
      end
      if (no_idle) begin
        stall = 0;
        out_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(fpa_pkg::OP_ADD, POS_MAX, 32'd1);
    send_op(fpa_pkg::OP_ADD, NEG_MIN, 32'hffff_ffff);
    send_op(fpa_pkg::OP_SUB, NEG_MIN, 32'd1);
    send_op(fpa_pkg::OP_SUB, 32'd0, NEG_MIN);
    send_op(fpa_pkg::OP_MUL, NEG_MIN, NEG_MIN);
    send_op(fpa_pkg::OP_MUL, NEG_MIN, POS_MAX);
    // exact halves: round away from zero
    send_op(fpa_pkg::OP_MUL, 32'd1, 32'd128);
    send_op(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'd128);
    send_op(fpa_pkg::OP_DIV, 32'h1234_5678, 32'd0);
    send_op(fpa_pkg::OP_DIV, 32'd1, 32'd512);
    send_op(fpa_pkg::OP_DIV, 32'hffff_ffff, 32'd512);
    send_op(fpa_pkg::OP_DIV, NEG_MIN, 32'd1);
    send_op(fpa_pkg::OP_GT, POS_MAX, NEG_MIN);
    send_op(fpa_pkg::OP_LT, POS_MAX, NEG_MIN);
    send_op(fpa_pkg::OP_GE, NEG_MIN, NEG_MIN);
    send_op(fpa_pkg::OP_LE, 32'd5, 32'd5);
    send_op(fpa_pkg::OP_EQ, POS_MAX, POS_MAX);
    send_op(fpa_pkg::OP_NE, 32'd0, 32'hffff_ffff);
    send_op(fpa_pkg::OP_MIN, 32'd7, 32'd7);
    send_op(fpa_pkg::OP_MAX, NEG_MIN, POS_MAX);
    send_op(fpa_pkg::OP_INC, POS_MAX, 32'd0);
    send_op(fpa_pkg::OP_DEC, NEG_MIN, 32'd0);
    send_op(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0);
    send_op(fpa_pkg::OP_FROM_INT, 32'hff80_0000, 32'd0);
    send_op(fpa_pkg::OP_TO_INT, 32'hffff_ffff, 32'd0);
    send_op(fpa_pkg::OP_TO_INT, NEG_MIN, POS_MAX);
  endtask

  task automatic test_random_ops(int n);
    repeat (n) send_random(1'b0);
  endtask

  task automatic test_back_to_back(int n);
    no_idle = 1'b1;
    repeat (n) send_random(1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_near_bounds(int n);
    repeat (n) send_random(1'b1);
  endtask

  // Hold off the sender until the pipeline has fully drained, several times over.
  task automatic test_drain_pause(int n);
    for (int i = 0; i < n; i++) begin
      send_random($urandom_range(0, 3) == 0);
      if (i % 25 == 24) wait_results_done(20000);
    end
  endtask

  initial begin
    int ops_hit;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    no_idle      = 1'b0;
    error_count  = 0;
    apply_reset();
    test_directed();
    test_random_ops(1000);
    test_back_to_back(200);
    test_near_bounds(150);
    test_drain_pause(100);
    wait_results_done(20000);
    repeat (2 * LATENCY) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_mismatch($sformatf("%s a=%h b=%h result never arrived",
                                pending_results[0].op.name(), pending_results[0].a,
                                pending_results[0].b));
      void'(pending_results.pop_front());
    end
    ops_hit = 0;
    foreach (op_sent[i]) if (op_sent[i] > 0) ops_hit++;
    $display("Covered %0d of 16 op codes; %0d result beats checked against the predictor.",
             ops_hit, checked_count);
    $display("Of these %0d saturated, %0d divided by zero and %0d comparisons held.",
             sat_count, div0_count, cmp_held_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
